[src/afu_pkg.sv]
// Shared types and constants for the activation function unit.
package afu_pkg;

   typedef enum logic [3:0] {
      MODE_LINEAR     = 4'd0,
      MODE_ABS        = 4'd1,
      MODE_CLAMP      = 4'd2,
      MODE_SIGMOID    = 4'd3,
      MODE_FAST_SIG   = 4'd4,
      MODE_SIG_DERIV  = 4'd5,
      MODE_TANH       = 4'd6,
      MODE_TANH_DERIV = 4'd7,
      MODE_GAUSS      = 4'd8,
      MODE_MQUAD      = 4'd9,
      MODE_STEP       = 4'd10
   } mode_type;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_MODE = 1'b0;

   localparam int Q30_W = 31;
   localparam int REM_W = 62;
   localparam int DEN_W = 32;
   localparam logic [Q30_W-1:0] ONE30 = 31'h4000_0000;

   // exp(-1) in Q30 as the series truncated after its 1/15! term gives it.
   function automatic logic [Q30_W-1:0] exp_neg_one();
      logic [63:0] term;
      logic signed [63:0] sum;
      term = 64'd1 << 30;
      sum  = 64'sd1 <<< 30;
      for (int n = 1; n <= 15; n++) begin
         term = term / 64'(n);
         if ((n & 1) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
         sum = 64'sd1 <<< 30;
      end
      return Q30_W'(sum);
   endfunction

   localparam logic [Q30_W-1:0] E1 = exp_neg_one();

endpackage

[src/afu_if.sv]
// Valid/ready channel interfaces for samples and results.
interface afu_req_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample;
   logic                         last_in;
   modport source (output valid, sample, last_in, input ready);
   modport sink (input valid, sample, last_in, output ready);
endinterface

interface afu_rsp_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] activation;
   logic                         last_out;
   modport source (output valid, activation, last_out, input ready);
   modport sink (input valid, activation, last_out, output ready);
endinterface

[src/activation_function_unit.sv]
// Activation function unit: a chain of cells that computes one Q-format activation per sample.
// Each sample passes through stage 0, stage 1, the series, scaling and divider cells, post
// stages 1 and 2, and SQ_CELLS square-root cells before the output buffer, where
// SQ_CELLS = (max(2*FRAC_BITS, 2*DATA_WIDTH-2) + 2) / 2.
// Throughput: one transaction per cycle while the output buffer has room; every register of
// the series, scaling, divider and square-root chains holds one sample and passes it on.
// Reset (synchronous, active high) clears all stage valid bits, the output buffer and the mode.
module activation_function_unit
   import afu_pkg::*;
#(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   afu_req_if.sink               req,
   afu_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int DW       = DATA_WIDTH;
   localparam int F        = FRAC_BITS;
   localparam int SQ_W     = ((2 * F > 2 * DW - 2) ? 2 * F : 2 * DW - 2) + 2;
   localparam int SQ_CELLS = SQ_W / 2;
   localparam int SAT_W    = 36;
   localparam int FRW      = 2 * DW + 2 * F + 32;
   localparam int SH_A     = (F >= 30) ? F - 30 : 30 - F;
   localparam int SH_B     = (2 * F >= 30) ? 2 * F - 30 : 30 - 2 * F;
   localparam logic signed [SAT_W-1:0] ONE_S  = SAT_W'(1) << F;
   localparam logic signed [SAT_W-1:0] SAT_HI = (SAT_W'(1) << (DW - 1)) - SAT_W'(1);
   localparam logic signed [SAT_W-1:0] SAT_LO = -(SAT_W'(1) << (DW - 1));
   localparam logic [31:0] RND = 32'(1) << (29 - F);

   // Everything one sample carries down the chain. Each cell rewrites only its own fields.
   typedef struct packed {
      logic                    vld;
      logic                    last;
      logic [3:0]              mode;
      logic                    neg;
      logic [DW-1:0]           m;
      logic signed [DW-1:0]    res;
      logic [4:0]              k;
      logic                    kz;
      logic [29:0]             f;
      logic [Q30_W-1:0]        term;
      logic [Q30_W-1:0]        prod_q;
      logic signed [32:0]      sum;
      logic [Q30_W-1:0]        e;
      logic [REM_W-1:0]        rem;
      logic [DEN_W-1:0]        den;
      logic [Q30_W-1:0]        q;
      logic [Q30_W-1:0]        w;
      logic [SQ_W-1:0]         sq_n;
      logic [SQ_W-1:0]         sq_r;
   } stage_type;

   function automatic logic signed [DW-1:0] saturate(input logic signed [SAT_W-1:0] v);
      if (v > SAT_HI) begin
         return DW'(SAT_HI);
      end else if (v < SAT_LO) begin
         return DW'(SAT_LO);
      end
      return DW'(v);
   endfunction

   // ---------------------------------------------------------------------------------
   // Configuration port. The mode register is written during the APB access phase.
   // ---------------------------------------------------------------------------------
   logic [3:0] mode_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 4'd0;
      end else if (csr_write && (csr_paddr[2] == CSR_IDX_MODE)) begin
         mode_ff <= csr_pwdata[3:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MODE) ? {28'd0, mode_ff} : 32'd0;

   // ---------------------------------------------------------------------------------
   // The whole chain advances together whenever the output buffer has room, so an
   // incoming transaction is taken even while a finished result waits at the output.
   // ---------------------------------------------------------------------------------
   logic       adv;
   logic       push, pop;
   logic [1:0] count_ff, count_in;

   assign adv       = (count_ff != 2'd2);
   assign req.ready = adv;

   stage_type p0_in, p0_ff, p1_in, p1_ff, dp_in, dp_ff, po1_in, po1_ff, po2_in, po2_ff;
   stage_type scale_head, fin;
   stage_type ser_link [0:15];
   stage_type scale_link [0:31];
   stage_type div_link [0:31];
   stage_type sq_link [0:SQ_CELLS];

   // Stage 0: magnitude and the modes that need no arithmetic beyond a compare.
   logic signed [SAT_W-1:0] sx, cl;

   always_comb begin
      p0_in      = '0;
      p0_in.vld  = req.valid;
      p0_in.last = req.last_in;
      p0_in.mode = mode_ff;
      p0_in.neg  = req.sample[DW-1];
      p0_in.m    = p0_in.neg ? DW'(~req.sample + 1'b1) : DW'(req.sample);
      sx = SAT_W'(req.sample);
      cl = (sx > ONE_S) ? ONE_S : ((sx < -ONE_S) ? -ONE_S : sx);
      case (mode_ff)
         MODE_LINEAR: p0_in.res = req.sample;
         MODE_ABS:    p0_in.res = saturate($signed(SAT_W'(p0_in.m)));
         MODE_CLAMP:  p0_in.res = saturate(cl);
         MODE_STEP:   p0_in.res = (sx > 0) ? saturate(ONE_S) : '0;
         default:     p0_in.res = '0;
      endcase
   end

   // Stage 1: the exponent argument split into an integer part and a Q30 fraction.
   // Sigmoid modes use |x|, tanh modes 2|x|, and the Gaussian x squared with twice the
   // fraction bits. The multiquadric radicand comes from the same square.
   logic [2*DW-1:0] mm;
   logic [DW:0]     n_a, kf_a;
   logic [2*DW-1:0] kf_b;
   logic [FRW-1:0]  fr_a, fr_b;
   logic [29:0]     f_a, f_b;

   always_comb begin
      p1_in = p0_ff;
      mm = (2 * DW)'(p0_ff.m) * (2 * DW)'(p0_ff.m);
      if (p0_ff.mode inside {MODE_TANH, MODE_TANH_DERIV}) begin
         n_a = {p0_ff.m, 1'b0};
      end else begin
         n_a = {1'b0, p0_ff.m};
      end
      kf_a = n_a >> F;
      fr_a = FRW'(n_a) & ((FRW'(1) << F) - FRW'(1));
      f_a  = (F >= 30) ? 30'(fr_a >> SH_A) : 30'(fr_a << SH_A);
      kf_b = mm >> (2 * F);
      fr_b = FRW'(mm) & ((FRW'(1) << (2 * F)) - FRW'(1));
      f_b  = (2 * F >= 30) ? 30'(fr_b >> SH_B) : 30'(fr_b << SH_B);
      if (p0_ff.mode == MODE_GAUSS) begin
         p1_in.k  = kf_b[4:0];
         p1_in.kz = (kf_b >= (2 * DW)'(32));
         p1_in.f  = f_b;
      end else begin
         p1_in.k  = kf_a[4:0];
         p1_in.kz = (kf_a >= (DW + 1)'(32));
         p1_in.f  = f_a;
      end
      p1_in.term = ONE30;
      p1_in.sum  = $signed(33'(ONE30));
      p1_in.sq_n = SQ_W'(mm) + (SQ_W'(1) << (2 * F));
      p1_in.sq_r = '0;
   end

   // Fifteen series cells build exp(-f); each term divides by its own index.
   assign ser_link[0] = p1_ff;

   for (genvar i = 0; i < 15; i++) begin : g_series
      afu_series_cell #(.stage_type(stage_type), .N(i + 1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .src_stage (ser_link[i]),
         .dst_stage (ser_link[i+1])
      );
   end

   // The partial sum is held to [0, 1.0] before scaling by powers of exp(-1).
   always_comb begin
      scale_head = ser_link[15];
      if (ser_link[15].sum < 0) begin
         scale_head.e = '0;
      end else if (ser_link[15].sum > $signed(33'(ONE30))) begin
         scale_head.e = ONE30;
      end else begin
         scale_head.e = Q30_W'(ser_link[15].sum);
      end
   end

   assign scale_link[0] = scale_head;

   for (genvar i = 0; i < 31; i++) begin : g_scale
      afu_scale_cell #(.stage_type(stage_type), .I(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .src_stage (scale_link[i]),
         .dst_stage (scale_link[i+1])
      );
   end

   // Divider operands. An integer part of 32 or more makes the exponential zero.
   logic [Q30_W-1:0] e_v;
   logic [DEN_W-1:0] den_fs;

   always_comb begin
      dp_in = scale_link[31];
      e_v = scale_link[31].kz ? '0 : scale_link[31].e;
      dp_in.e = e_v;
      dp_in.q = '0;
      dp_in.den = DEN_W'(ONE30) + DEN_W'(e_v);
      den_fs = (DEN_W'(1) << F) + DEN_W'(scale_link[31].m);
      case (scale_link[31].mode)
         MODE_SIGMOID: begin
            if (scale_link[31].neg) begin
               dp_in.rem = REM_W'(e_v) << 30;
            end else begin
               dp_in.rem = REM_W'(1) << 60;
            end
         end
         MODE_TANH, MODE_TANH_DERIV: dp_in.rem = REM_W'(ONE30 - e_v) << 30;
         MODE_FAST_SIG: begin
            dp_in.den = den_fs;
            dp_in.rem = (REM_W'(scale_link[31].m) << F) + REM_W'(den_fs >> 1);
         end
         default: dp_in.rem = REM_W'(1) << 60;
      endcase
   end

   assign div_link[0] = dp_ff;

   for (genvar i = 0; i < 31; i++) begin : g_div
      afu_div_cell #(.stage_type(stage_type), .J(30 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .src_stage (div_link[i]),
         .dst_stage (div_link[i+1])
      );
   end

   // Post stage 1: the derivative modes share one multiplier, 1 - v against v or 1 + v.
   logic [Q30_W-1:0] mul_a;
   logic [31:0]      mul_b;
   logic [62:0]      mul_p;

   always_comb begin
      po1_in = div_link[31];
      mul_a = ONE30 - div_link[31].q;
      if (div_link[31].mode == MODE_SIG_DERIV) begin
         mul_b = 32'(div_link[31].q);
      end else begin
         mul_b = 32'(ONE30) + 32'(div_link[31].q);
      end
      mul_p = 63'(mul_a) * 63'(mul_b);
      case (div_link[31].mode)
         MODE_SIG_DERIV, MODE_TANH_DERIV: po1_in.w = mul_p[60:30];
         MODE_GAUSS:                      po1_in.w = div_link[31].e;
         default:                         po1_in.w = div_link[31].q;
      endcase
   end

   // Post stage 2: Q30 rounded half up to the output format, sign applied, saturated.
   logic signed [SAT_W-1:0] fq, qs;

   always_comb begin
      po2_in = po1_ff;
      fq = $signed(SAT_W'((32'(po1_ff.w) + RND) >> (30 - F)));
      qs = $signed(SAT_W'(po1_ff.q));
      case (po1_ff.mode)
         MODE_SIGMOID, MODE_SIG_DERIV, MODE_TANH_DERIV, MODE_GAUSS: begin
            po2_in.res = saturate(fq);
         end
         MODE_TANH:     po2_in.res = saturate(po1_ff.neg ? -fq : fq);
         MODE_FAST_SIG: po2_in.res = saturate(po1_ff.neg ? -qs : qs);
         default:       po2_in.res = po1_ff.res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_ff.vld  <= 1'b0;
         p1_ff.vld  <= 1'b0;
         dp_ff.vld  <= 1'b0;
         po1_ff.vld <= 1'b0;
         po2_ff.vld <= 1'b0;
      end else if (adv) begin
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         dp_ff  <= dp_in;
         po1_ff <= po1_in;
         po2_ff <= po2_in;
      end
   end

   // Square-root cells, most significant root bit first.
   assign sq_link[0] = po2_ff;

   for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
      afu_sqrt_cell #(.stage_type(stage_type), .SQ_W(SQ_W), .B(SQ_CELLS - 1 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .src_stage (sq_link[i]),
         .dst_stage (sq_link[i+1])
      );
   end

   // The floor root is rounded up when the remainder exceeds it.
   logic [SAT_W-1:0] root;

   always_comb begin
      fin = sq_link[SQ_CELLS];
      root = SAT_W'(sq_link[SQ_CELLS].sq_r)
           + SAT_W'(sq_link[SQ_CELLS].sq_n > sq_link[SQ_CELLS].sq_r);
      if (sq_link[SQ_CELLS].mode == MODE_MQUAD) begin
         fin.res = saturate($signed(root));
      end
   end

   // ---------------------------------------------------------------------------------
   // Two-entry output buffer. Entry 0 is the head shown on the result channel.
   // ---------------------------------------------------------------------------------
   logic signed [DW-1:0] act_ff [2];
   logic                 last_ff [2];
   logic                 wslot;

   assign push     = adv && fin.vld;
   assign pop      = rsp.valid && rsp.ready;
   assign count_in = 2'(count_ff + {1'b0, push} - {1'b0, pop});
   assign wslot    = 1'(count_ff - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A new result lands in the head when the buffer is empty or empties in this cycle; otherwise
   // the head takes the second entry whenever a transaction leaves.
   always_ff @(posedge clock) begin
      if (push && (wslot == 1'b0)) begin
         act_ff[0]  <= fin.res;
         last_ff[0] <= fin.last;
      end else if (pop) begin
         act_ff[0]  <= act_ff[1];
         last_ff[0] <= last_ff[1];
      end
      if (push && (wslot == 1'b1)) begin
         act_ff[1]  <= fin.res;
         last_ff[1] <= fin.last;
      end
   end

   assign rsp.valid      = (count_ff != 2'd0);
   assign rsp.activation = act_ff[0];
   assign rsp.last_out   = last_ff[0];

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2))
      else $error("result pushed into a full output buffer");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> (count_ff == 2'd2))
      else $error("output buffer changed while full and stalled");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !push && count_ff == 2'd1) |=> (count_ff == 2'd0))
      else $error("output buffer failed to drain its last entry");
`endif

endmodule

[src/afu_series_cell.sv]
// One Taylor term of the exp(-f) series, split over two register stages.
module afu_series_cell
   import afu_pkg::*;
#(
   parameter type stage_type = logic,
   parameter int  N          = 1
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  stage_type src_stage,
   output stage_type dst_stage
);

   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);

   stage_type   mid_in, mid_ff, out_in, out_ff;
   logic [60:0] prod;
   logic [65:0] est;
   logic [30:0] quo_est, quo;
   logic [31:0] rem_est;

   always_comb begin
      mid_in = src_stage;
      prod = 61'(src_stage.term) * 61'(src_stage.f);
      mid_in.prod_q = prod[60:30];
   end

   // Division by the term index through a reciprocal, corrected by one step.
   always_comb begin
      out_in = mid_ff;
      est = 66'(mid_ff.prod_q) * 66'(RECIP);
      quo_est = est[62:32];
      rem_est = 32'(mid_ff.prod_q) - 32'(32'(quo_est) * 32'(N));
      quo = (rem_est >= 32'(N)) ? quo_est + 31'd1 : quo_est;
      out_in.term = quo;
      if ((N % 2) == 1) begin
         out_in.sum = mid_ff.sum - $signed({2'b00, quo});
      end else begin
         out_in.sum = mid_ff.sum + $signed({2'b00, quo});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.vld <= 1'b0;
         out_ff.vld <= 1'b0;
      end else if (adv) begin
         mid_ff <= mid_in;
         out_ff <= out_in;
      end
   end

   assign dst_stage = out_ff;

endmodule

[src/afu_scale_cell.sv]
// Multiplies the exponential by exp(-1) when the integer part exceeds this cell's index.
module afu_scale_cell
   import afu_pkg::*;
#(
   parameter type stage_type = logic,
   parameter int  I          = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  stage_type src_stage,
   output stage_type dst_stage
);

   stage_type   out_in, out_ff;
   logic [61:0] prod;

   always_comb begin
      out_in = src_stage;
      prod = 62'(src_stage.e) * 62'(E1);
      if (!src_stage.kz && (src_stage.k > 5'(I))) begin
         out_in.e = prod[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld <= 1'b0;
      end else if (adv) begin
         out_ff <= out_in;
      end
   end

   assign dst_stage = out_ff;

endmodule

[src/afu_div_cell.sv]
// One quotient bit of a restoring divider.
module afu_div_cell
   import afu_pkg::*;
#(
   parameter type stage_type = logic,
   parameter int  J          = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  stage_type src_stage,
   output stage_type dst_stage
);

   stage_type        out_in, out_ff;
   logic [REM_W-1:0] trial;

   always_comb begin
      out_in = src_stage;
      trial = REM_W'(src_stage.den) << J;
      if (src_stage.rem >= trial) begin
         out_in.rem  = src_stage.rem - trial;
         out_in.q[J] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld <= 1'b0;
      end else if (adv) begin
         out_ff <= out_in;
      end
   end

   assign dst_stage = out_ff;

endmodule

[src/afu_sqrt_cell.sv]
// One root bit of a digit-by-digit integer square root.
module afu_sqrt_cell
   import afu_pkg::*;
#(
   parameter type stage_type = logic,
   parameter int  SQ_W       = 32,
   parameter int  B          = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  stage_type src_stage,
   output stage_type dst_stage
);

   localparam logic [SQ_W:0] BITV = (SQ_W + 1)'(1) << (2 * B);

   stage_type     out_in, out_ff;
   logic [SQ_W:0] trial;

   always_comb begin
      out_in = src_stage;
      trial = {1'b0, src_stage.sq_r} + BITV;
      if ({1'b0, src_stage.sq_n} >= trial) begin
         out_in.sq_n = SQ_W'({1'b0, src_stage.sq_n} - trial);
         out_in.sq_r = SQ_W'({1'b0, src_stage.sq_r >> 1} + BITV);
      end else begin
         out_in.sq_r = src_stage.sq_r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld <= 1'b0;
      end else if (adv) begin
         out_ff <= out_in;
      end
   end

   assign dst_stage = out_ff;

endmodule
